>>> hdl/s2kt_pkg.sv
`timescale 1ns / 1ps
package s2kt_pkg;

   localparam int COORD_BITS    = 16;
   localparam int TABLE_DEPTH_D = 1024;
   localparam int VIEW_BITS     = 7;
   localparam int COUNT_BITS    = 11;
   localparam int STATUS_BITS   = 3;
   localparam int CSR_IDX_BITS  = 1;
   localparam logic [VIEW_BITS-1:0] VIEW_RESET = VIEW_BITS'(8);

   typedef enum logic [1:0] {
      REQ_INSERT  = 2'd0,
      REQ_DELETE  = 2'd1,
      REQ_REFRESH = 2'd2
   } req_code_type;

   typedef enum logic [STATUS_BITS-1:0] {
      RSP_INSERTED  = 3'd0,
      RSP_PRESENT   = 3'd1,
      RSP_DELETED   = 3'd2,
      RSP_NOT_FOUND = 3'd3,
      RSP_FULL      = 3'd4,
      RSP_REFRESHED = 3'd5
   } rsp_code_type;

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_VIEW_WIDTH  = 1'd0,
      CSR_VIEW_HEIGHT = 1'd1
   } csr_code_type;

   typedef struct packed {
      logic [1:0]                   req_type;
      logic signed [COORD_BITS-1:0] key_x;
      logic signed [COORD_BITS-1:0] key_y;
   } req_payload_type;

   typedef struct packed {
      logic [STATUS_BITS-1:0] status;
      logic [COUNT_BITS-1:0]  entry_count;
   } rsp_payload_type;

   typedef enum logic [2:0] {
      RD_NONE, RD_MID, RD_LO, RD_IDX, RD_IDX_M1
   } rd_sel_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_KEY_LO, WR_DATA_IDX, WR_DATA_IDX_M1, WR_DATA_W
   } wr_sel_type;

   typedef struct packed {
      logic                   load_req;
      logic                   load_rect_key;
      logic                   search_init;
      logic                   search_step;
      rd_sel_type             rd_sel;
      wr_sel_type             wr_sel;
      logic                   idx_used;
      logic                   idx_lo_p1;
      logic                   idx_inc;
      logic                   idx_dec;
      logic                   prune_init;
      logic                   w_inc;
      logic                   used_inc;
      logic                   used_dec;
      logic                   used_from_w;
      logic                   changed_clr;
      logic                   row_clr;
      logic                   row_inc;
      logic                   col_clr;
      logic                   col_inc;
      logic                   cam_load;
      logic                   rsp_load;
      logic [STATUS_BITS-1:0] rsp_status;
   } cmd_type;

   typedef struct packed {
      logic lo_lt_hi;
      logic lo_lt_used;
      logic hit;
      logic full;
      logic idx_gt_lo;
      logic idx_lt_used;
      logic keep;
      logic changed;
      logic cam_moved;
      logic row_lt_h;
      logic y_ok;
      logic col_lt_w;
      logic x_ok;
      logic out_free;
   } stat_type;

endpackage

>>> hdl/s2kt_datapath.sv
`timescale 1ns / 1ps
module s2kt_datapath #(
   parameter int TABLE_DEPTH = s2kt_pkg::TABLE_DEPTH_D
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  s2kt_pkg::req_payload_type             req_payload,
   input  logic                                  csr_write_en,
   input  logic [s2kt_pkg::CSR_IDX_BITS-1:0]     csr_index,
   input  logic [s2kt_pkg::VIEW_BITS-1:0]        csr_wdata,
   input  s2kt_pkg::cmd_type                     cmd,
   output s2kt_pkg::stat_type                    stat,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output s2kt_pkg::rsp_payload_type             rsp_payload
);
   import s2kt_pkg::*;

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int KW = 2 * COORD_BITS;
   localparam int EW = COORD_BITS + 2;
   localparam logic signed [EW-1:0] CMIN = -(EW'(1) <<< (COORD_BITS - 1));
   localparam logic signed [EW-1:0] CMAX = (EW'(1) <<< (COORD_BITS - 1)) - EW'(1);

   logic [KW-1:0] mem [TABLE_DEPTH];
   logic [KW-1:0] rd_ff;

   logic signed [COORD_BITS-1:0] kx_ff, ky_ff, cx_ff, cy_ff, camx_ff, camy_ff;
   logic [CW-1:0] used_ff, lo_ff, hi_ff, idx_ff, w_ff;
   logic          changed_ff;
   logic [VIEW_BITS-1:0] vw_ff, vh_ff, row_ff, col_ff;
   logic          rsp_valid_ff;
   rsp_payload_type rsp_ff;

   logic [CW-1:0] mid, rd_addr_w, wr_addr_w;
   logic          rd_en, wr_en;
   logic [KW-1:0] wr_data;
   logic signed [COORD_BITS-1:0] rx, ry;
   logic signed [EW-1:0] hw, hh, cxe, cye, rxe, rye, x_cur, y_cur;
   logic          rd_less;

   assign mid = lo_ff + ((hi_ff - lo_ff) >> 1);
   assign rx  = rd_ff[KW-1:COORD_BITS];
   assign ry  = rd_ff[COORD_BITS-1:0];
   assign hw  = EW'(vw_ff >> 1);
   assign hh  = EW'(vh_ff >> 1);
   assign cxe = EW'(cx_ff);
   assign cye = EW'(cy_ff);
   assign rxe = EW'(rx);
   assign rye = EW'(ry);
   assign x_cur = cxe - hw + EW'(col_ff);
   assign y_cur = cye - hh + EW'(row_ff);
   assign rd_less = (rx < kx_ff) || ((rx == kx_ff) && (ry < ky_ff));

   always_comb begin
      rd_en     = 1'b1;
      rd_addr_w = lo_ff;
      case (cmd.rd_sel)
         RD_MID:    rd_addr_w = mid;
         RD_LO:     rd_addr_w = lo_ff;
         RD_IDX:    rd_addr_w = idx_ff;
         RD_IDX_M1: rd_addr_w = idx_ff - CW'(1);
         default:   rd_en     = 1'b0;
      endcase
   end

   always_comb begin
      wr_en     = 1'b1;
      wr_addr_w = lo_ff;
      wr_data   = rd_ff;
      case (cmd.wr_sel)
         WR_KEY_LO: begin
            wr_addr_w = lo_ff;
            wr_data   = {kx_ff, ky_ff};
         end
         WR_DATA_IDX:    wr_addr_w = idx_ff;
         WR_DATA_IDX_M1: wr_addr_w = idx_ff - CW'(1);
         WR_DATA_W:      wr_addr_w = w_ff;
         default:        wr_en     = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr_w[AW-1:0]] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem[rd_addr_w[AW-1:0]];
      end
   end

   always_comb begin
      stat.lo_lt_hi    = lo_ff < hi_ff;
      stat.lo_lt_used  = lo_ff < used_ff;
      stat.hit         = (lo_ff < used_ff) && (rx == kx_ff) && (ry == ky_ff);
      stat.full        = used_ff >= CW'(TABLE_DEPTH);
      stat.idx_gt_lo   = idx_ff > lo_ff;
      stat.idx_lt_used = idx_ff < used_ff;
      stat.keep        = !((rxe < cxe - hw) || (rxe >= cxe + hw) ||
                           (rye < cye - hh) || (rye > cye + hh));
      stat.changed     = changed_ff;
      stat.cam_moved   = (camx_ff != cx_ff) || (camy_ff != cy_ff);
      stat.row_lt_h    = row_ff < vh_ff;
      stat.y_ok        = (y_cur >= CMIN) && (y_cur <= CMAX);
      stat.col_lt_w    = col_ff < vw_ff;
      stat.x_ok        = (x_cur >= CMIN) && (x_cur <= CMAX);
      stat.out_free    = !rsp_valid_ff || !rsp_stall;
   end

   // working registers, not reset
   always_ff @(posedge clock) begin
      if (cmd.load_req) begin
         kx_ff <= req_payload.key_x;
         ky_ff <= req_payload.key_y;
         cx_ff <= req_payload.key_x;
         cy_ff <= req_payload.key_y;
      end else if (cmd.load_rect_key) begin
         kx_ff <= x_cur[COORD_BITS-1:0];
         ky_ff <= y_cur[COORD_BITS-1:0];
      end
      if (cmd.search_init) begin
         lo_ff <= '0;
         hi_ff <= used_ff;
      end else if (cmd.search_step) begin
         if (rd_less) begin
            lo_ff <= mid + CW'(1);
         end else begin
            hi_ff <= mid;
         end
      end
      if (cmd.idx_used) begin
         idx_ff <= used_ff;
      end else if (cmd.idx_lo_p1) begin
         idx_ff <= lo_ff + CW'(1);
      end else if (cmd.prune_init) begin
         idx_ff <= '0;
      end else if (cmd.idx_inc) begin
         idx_ff <= idx_ff + CW'(1);
      end else if (cmd.idx_dec) begin
         idx_ff <= idx_ff - CW'(1);
      end
      if (cmd.prune_init) begin
         w_ff <= '0;
      end else if (cmd.w_inc) begin
         w_ff <= w_ff + CW'(1);
      end
      if (cmd.row_clr) begin
         row_ff <= '0;
      end else if (cmd.row_inc) begin
         row_ff <= row_ff + VIEW_BITS'(1);
      end
      if (cmd.col_clr) begin
         col_ff <= '0;
      end else if (cmd.col_inc) begin
         col_ff <= col_ff + VIEW_BITS'(1);
      end
      if (cmd.rsp_load) begin
         rsp_ff.status      <= cmd.rsp_status;
         rsp_ff.entry_count <= COUNT_BITS'(used_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff      <= '0;
         changed_ff   <= 1'b0;
         camx_ff      <= '0;
         camy_ff      <= '0;
         vw_ff        <= VIEW_RESET;
         vh_ff        <= VIEW_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.used_inc) begin
            used_ff    <= used_ff + CW'(1);
            changed_ff <= 1'b1;
         end else if (cmd.used_dec) begin
            used_ff    <= used_ff - CW'(1);
            changed_ff <= 1'b1;
         end else if (cmd.used_from_w) begin
            used_ff <= w_ff;
         end
         if (cmd.changed_clr) begin
            changed_ff <= 1'b0;
         end
         if (cmd.cam_load) begin
            camx_ff <= cx_ff;
            camy_ff <= cy_ff;
         end
         if (csr_write_en) begin
            case (csr_index)
               CSR_VIEW_WIDTH:  vw_ff <= csr_wdata;
               CSR_VIEW_HEIGHT: vh_ff <= csr_wdata;
               default: ;
            endcase
         end
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hdl/s2kt_ctrl.sv
`timescale 1ns / 1ps
module s2kt_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  logic [1:0]          req_type,
   output logic                req_stall,
   input  s2kt_pkg::stat_type  stat,
   output s2kt_pkg::cmd_type   cmd
);
   import s2kt_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE, S_SCHK, S_SWAIT, S_HCHK, S_UP_CHK, S_UP_WR, S_DN_CHK, S_DN_WR,
      S_REF, S_P_CHK, S_P_EVAL, S_CAM, S_ROW, S_COL, S_FIN
   } state_type;

   typedef enum logic [1:0] {M_INS, M_DEL, M_RECT} mode_type;

   state_type    state_ff, state_in;
   mode_type     mode_ff, mode_in;
   rsp_code_type code_ff, code_in;

   assign req_stall = state_ff != S_IDLE;

   always_comb begin
      cmd          = '0;
      cmd.rd_sel   = RD_NONE;
      cmd.wr_sel   = WR_NONE;
      cmd.rsp_status = code_ff;
      state_in     = state_ff;
      mode_in      = mode_ff;
      code_in      = code_ff;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_req = 1'b1;
               if (req_type == REQ_INSERT || req_type == REQ_DELETE) begin
                  cmd.search_init = 1'b1;
                  if (req_type == REQ_INSERT) begin
                     mode_in = M_INS;
                  end else begin
                     mode_in = M_DEL;
                  end
                  state_in = S_SCHK;
               end else begin
                  state_in = S_REF;
               end
            end
         end
         S_SCHK: begin
            if (stat.lo_lt_hi) begin
               cmd.rd_sel = RD_MID;
               state_in   = S_SWAIT;
            end else begin
               cmd.rd_sel = RD_LO;
               state_in   = S_HCHK;
            end
         end
         S_SWAIT: begin
            cmd.search_step = 1'b1;
            state_in        = S_SCHK;
         end
         S_HCHK: begin
            if (mode_ff == M_DEL) begin
               if (!stat.hit) begin
                  code_in  = RSP_NOT_FOUND;
                  state_in = S_FIN;
               end else begin
                  cmd.idx_lo_p1 = 1'b1;
                  state_in      = S_DN_CHK;
               end
            end else if (stat.hit || stat.full) begin
               if (mode_ff == M_RECT) begin
                  cmd.col_inc = 1'b1;
                  state_in    = S_COL;
               end else begin
                  if (stat.hit) begin
                     code_in = RSP_PRESENT;
                  end else begin
                     code_in = RSP_FULL;
                  end
                  state_in = S_FIN;
               end
            end else begin
               cmd.idx_used = 1'b1;
               state_in     = S_UP_CHK;
            end
         end
         S_UP_CHK: begin
            if (stat.idx_gt_lo) begin
               cmd.rd_sel = RD_IDX_M1;
               state_in   = S_UP_WR;
            end else begin
               cmd.wr_sel   = WR_KEY_LO;
               cmd.used_inc = 1'b1;
               if (mode_ff == M_RECT) begin
                  cmd.col_inc = 1'b1;
                  state_in    = S_COL;
               end else begin
                  code_in  = RSP_INSERTED;
                  state_in = S_FIN;
               end
            end
         end
         S_UP_WR: begin
            cmd.wr_sel  = WR_DATA_IDX;
            cmd.idx_dec = 1'b1;
            state_in    = S_UP_CHK;
         end
         S_DN_CHK: begin
            if (stat.idx_lt_used) begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_DN_WR;
            end else begin
               cmd.used_dec = 1'b1;
               code_in      = RSP_DELETED;
               state_in     = S_FIN;
            end
         end
         S_DN_WR: begin
            cmd.wr_sel  = WR_DATA_IDX_M1;
            cmd.idx_inc = 1'b1;
            state_in    = S_DN_CHK;
         end
         S_REF: begin
            if (stat.changed) begin
               cmd.prune_init = 1'b1;
               state_in       = S_P_CHK;
            end else begin
               state_in = S_CAM;
            end
         end
         S_P_CHK: begin
            if (stat.idx_lt_used) begin
               cmd.rd_sel = RD_IDX;
               state_in   = S_P_EVAL;
            end else begin
               cmd.used_from_w = 1'b1;
               cmd.changed_clr = 1'b1;
               state_in        = S_CAM;
            end
         end
         S_P_EVAL: begin
            if (stat.keep) begin
               cmd.wr_sel = WR_DATA_W;
               cmd.w_inc  = 1'b1;
            end
            cmd.idx_inc = 1'b1;
            state_in    = S_P_CHK;
         end
         S_CAM: begin
            if (stat.cam_moved) begin
               cmd.row_clr = 1'b1;
               state_in    = S_ROW;
            end else begin
               code_in  = RSP_REFRESHED;
               state_in = S_FIN;
            end
         end
         S_ROW: begin
            if (!stat.row_lt_h) begin
               cmd.cam_load = 1'b1;
               code_in      = RSP_REFRESHED;
               state_in     = S_FIN;
            end else if (stat.y_ok) begin
               cmd.col_clr = 1'b1;
               state_in    = S_COL;
            end else begin
               cmd.row_inc = 1'b1;
            end
         end
         S_COL: begin
            if (!stat.col_lt_w) begin
               cmd.row_inc = 1'b1;
               state_in    = S_ROW;
            end else if (stat.x_ok) begin
               cmd.load_rect_key = 1'b1;
               cmd.search_init   = 1'b1;
               mode_in           = M_RECT;
               state_in          = S_SCHK;
            end else begin
               cmd.col_inc = 1'b1;
            end
         end
         S_FIN: begin
            if (stat.out_free) begin
               cmd.rsp_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         mode_ff  <= M_INS;
         code_ff  <= RSP_INSERTED;
      end else begin
         state_ff <= state_in;
         mode_ff  <= mode_in;
         code_ff  <= code_in;
      end
   end

endmodule

>>> hdl/sorted_2d_key_table.sv
`timescale 1ns / 1ps
// Channel  Ports                                  Direction  Moves
// req      req_valid, req_stall, req_payload      in         insert/delete/refresh
// rsp      rsp_valid, rsp_stall, rsp_payload      out        status, entry_count
// csr      csr_write_en, csr_index, csr_wdata     in         view_width/height
//
// One transaction at a time. A lookup is a binary search over the single-port
// key memory, a read then a compare per halving step; insert/delete then move
// entries, a read then a write each. Refresh checks each stored key for pruning
// if the table changed and, if the camera moved, runs a full insert per rectangle
// position. Reset is synchronous and needs no memory clear. The result sits in an
// output register; a stalled rsp only holds the block in its final state.
module sorted_2d_key_table #(
   parameter int TABLE_DEPTH = s2kt_pkg::TABLE_DEPTH_D
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  s2kt_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output s2kt_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_write_en,
   input  logic [s2kt_pkg::CSR_IDX_BITS-1:0] csr_index,
   input  logic [s2kt_pkg::VIEW_BITS-1:0]    csr_wdata
);
   import s2kt_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   s2kt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_payload.req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   s2kt_datapath #(.TABLE_DEPTH(TABLE_DEPTH)) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_payload  (req_payload),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .cmd          (cmd),
      .stat         (stat),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_payload  (rsp_payload)
   );

   // a result is only produced while a transaction is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> req_stall)
      else $error("result loaded while idle");

   // never overwrite a result still waiting downstream
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      cmd.rsp_load |-> stat.out_free)
      else $error("result overrun");

   // count never exceeds the table
   a_count: assert property (@(posedge clock) disable iff (reset)
      cmd.used_inc |-> !stat.full)
      else $error("insert into full table");

   // a search hit must point inside the filled region
   a_hit: assert property (@(posedge clock) disable iff (reset)
      stat.hit |-> stat.lo_lt_used)
      else $error("hit beyond filled entries");

endmodule

>>> tb/sorted_2d_key_table_tb.sv
`timescale 1ns / 1ps
module sorted_2d_key_table_tb;
   import s2kt_pkg::*;

   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // Tracks the sorted key set, the view and the camera, and holds the
   // results still owed by the block.
   class key_table_scoreboard;
      int kx[$];
      int ky[$];
      bit changed;
      int cam_x, cam_y;
      int view_w, view_h;
      rsp_payload_type owed[$];
      int errors;

      function new();
         changed = 0;
         cam_x = 0;
         cam_y = 0;
         view_w = VIEW_RESET;
         view_h = VIEW_RESET;
         errors = 0;
      endfunction

      function int lower_pos(int x, int y);
         int i;
         for (i = 0; i < kx.size(); i++)
            if (kx[i] > x || (kx[i] == x && ky[i] >= y))
               return i;
         return kx.size();
      endfunction

      function rsp_code_type add_key(int x, int y);
         int p;
         p = lower_pos(x, y);
         if (p < kx.size() && kx[p] == x && ky[p] == y)
            return RSP_PRESENT;
         if (kx.size() >= TABLE_DEPTH_D)
            return RSP_FULL;
         kx.insert(p, x);
         ky.insert(p, y);
         changed = 1;
         return RSP_INSERTED;
      endfunction

      function rsp_code_type drop_key(int x, int y);
         int p;
         p = lower_pos(x, y);
         if (p >= kx.size() || kx[p] != x || ky[p] != y)
            return RSP_NOT_FOUND;
         kx.delete(p);
         ky.delete(p);
         changed = 1;
         return RSP_DELETED;
      endfunction

      function void refresh_view(int cx, int cy);
         int hw, hh, i, j, x, y;
         int nx[$], ny[$];
         rsp_code_type dummy;
         hw = view_w / 2;
         hh = view_h / 2;
         if (changed) begin
            for (i = 0; i < kx.size(); i++)
               if (!(kx[i] < cx - hw || kx[i] >= cx + hw ||
                     ky[i] < cy - hh || ky[i] > cy + hh)) begin
                  nx.push_back(kx[i]);
                  ny.push_back(ky[i]);
               end
            kx = nx;
            ky = ny;
            changed = 0;
         end
         if (cam_x != cx || cam_y != cy) begin
            for (i = 0; i < view_h; i++) begin
               y = cy - hh + i;
               if (y < -32768 || y > 32767)
                  continue;
               for (j = 0; j < view_w; j++) begin
                  x = cx - hw + j;
                  if (x < -32768 || x > 32767)
                     continue;
                  dummy = add_key(x, y);
               end
            end
            cam_x = cx;
            cam_y = cy;
         end
      endfunction

      function void note(req_payload_type p);
         rsp_payload_type r;
         int x, y;
         x = $signed(p.key_x);
         y = $signed(p.key_y);
         case (p.req_type)
            REQ_INSERT: r.status = add_key(x, y);
            REQ_DELETE: r.status = drop_key(x, y);
            default: begin
               refresh_view(x, y);
               r.status = RSP_REFRESHED;
            end
         endcase
         r.entry_count = COUNT_BITS'(kx.size());
         owed.push_back(r);
      endfunction

      function void check(rsp_payload_type r);
         rsp_payload_type e;
         if (owed.size() == 0) begin
            $display("%0t: unexpected transaction, status %0d count %0d",
                     $realtime, r.status, r.entry_count);
            errors++;
            return;
         end
         e = owed.pop_front();
         if (r.status !== e.status) begin
            $display("%0t: status expected %0d actual %0d", $realtime, e.status, r.status);
            errors++;
         end
         if (r.entry_count !== e.entry_count) begin
            $display("%0t: entry_count expected %0d actual %0d",
                     $realtime, e.entry_count, r.entry_count);
            errors++;
         end
      endfunction
   endclass

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall;
   req_payload_type req_payload;
   rsp_payload_type rsp_payload;
   logic csr_write_en;
   logic [CSR_IDX_BITS-1:0] csr_index;
   logic [VIEW_BITS-1:0] csr_wdata;

   key_table_scoreboard sb = new();
   bit quiet;
   bit squeeze;
   int cur_x, cur_y;

   sorted_2d_key_table dut (.*);

   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   initial begin
      #80000000;
      $display("end of test: mismatches");
      $finish;
   end

   function int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic send(logic [1:0] kind, int x, int y);
      req_payload_type p;
      int g;
      p.req_type = kind;
      p.key_x = x[15:0];
      p.key_y = y[15:0];
      req_valid <= 1'b1;
      req_payload <= p;
      do @(posedge clock); while (req_stall);
      sb.note(p);
      g = pick_gap();
      if (g > 0) begin
         req_valid <= 1'b0;
         repeat (g) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic set_view(int w, int h);
      csr_write_en <= 1'b1;
      csr_index <= CSR_VIEW_WIDTH;
      csr_wdata <= w[VIEW_BITS-1:0];
      @(posedge clock);
      csr_index <= CSR_VIEW_HEIGHT;
      csr_wdata <= h[VIEW_BITS-1:0];
      @(posedge clock);
      csr_write_en <= 1'b0;
      sb.view_w = w;
      sb.view_h = h;
   endtask

   function int near(int base, int span);
      int v;
      if ($urandom_range(0, 99) < 15)
         return $signed(16'($urandom()));
      v = base + $urandom_range(0, 2 * span) - span;
      return $signed(16'(v));
   endfunction

   // result side: random stall, one long hold-off to back the block up
   initial begin
      int hold;
      hold = 0;
      rsp_stall = 1'b0;
      @(negedge reset);
      forever begin
         @(posedge clock);
         if (rsp_valid && !rsp_stall)
            sb.check(rsp_payload);
         if (squeeze) begin
            squeeze = 1'b0;
            hold = 600;
         end
         if (hold > 0) begin
            hold--;
            rsp_stall <= 1'b1;
         end else if (quiet)
            rsp_stall <= 1'b0;
         else if ($urandom_range(0, 99) < 25)
            rsp_stall <= 1'b1;
         else if ($urandom_range(0, 99) < 2)
            hold = $urandom_range(10, 60);
         else
            rsp_stall <= 1'b0;
      end
   end

   initial begin
      int n, k, r, ph;
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      csr_write_en = 1'b0;
      csr_index = CSR_VIEW_WIDTH;
      csr_wdata = '0;
      quiet = 1'b0;
      squeeze = 1'b0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed
      send(REQ_INSERT, 0, 0);
      send(REQ_INSERT, 0, 0);
      send(REQ_DELETE, 0, 0);
      send(REQ_DELETE, 0, 0);
      send(REQ_INSERT, -32768, 32767);
      send(REQ_INSERT, 32767, -32768);
      send(REQ_INSERT, 3, 4);
      send(REQ_INSERT, -4, -4);
      send(REQ_INSERT, 4, 0);
      send(REQ_REFRESH, 0, 0);       // no move, prune only
      send(REQ_UNUSED, 2, 1);        // unused code acts as refresh
      send(REQ_REFRESH, -32768, -32768);
      send(REQ_REFRESH, 32767, 32767);
      wait_idle();
      set_view(64, 1);
      send(REQ_REFRESH, 5, -7);
      wait_idle();
      set_view(1, 64);
      send(REQ_REFRESH, -9, 11);
      wait_idle();
      // fill the table, then probe full, present, delete
      set_view(32, 32);
      send(REQ_REFRESH, 100, 100);
      send(REQ_INSERT, 0, 0);
      send(REQ_INSERT, 100, 100);
      send(REQ_DELETE, 100, 100);
      send(REQ_DELETE, 100, 100);
      send(REQ_INSERT, 100, 100);
      wait_idle();
      set_view(0, 5);
      send(REQ_REFRESH, 7, 7);       // zero width prunes everything
      wait_idle();
      set_view(5, 0);
      send(REQ_INSERT, 7, 7);
      send(REQ_REFRESH, 1, 1);
      cur_x = 1;
      cur_y = 1;

      for (ph = 0; ph < 6; ph++) begin
         wait_idle();
         if (ph == 5)
            set_view(64, 2);
         else
            set_view($urandom_range(0, 9), $urandom_range(0, 9));
         quiet = (ph == 2);
         // long receiver hold-off while requests keep coming
         if (ph == 1)
            squeeze = 1'b1;
         for (n = 0; n < 170; n++) begin
            r = $urandom_range(0, 99);
            if (r < 40)
               send(REQ_INSERT, near(cur_x, 8), near(cur_y, 8));
            else if (r < 75)
               send(REQ_DELETE, near(cur_x, 8), near(cur_y, 8));
            else begin
               k = $urandom_range(0, 99);
               if (k < 70) begin
                  cur_x = $signed(16'(cur_x + $urandom_range(0, 6) - 3));
                  cur_y = $signed(16'(cur_y + $urandom_range(0, 6) - 3));
               end else if (k >= 85) begin
                  cur_x = $signed(16'($urandom()));
                  cur_y = $signed(16'($urandom()));
               end
               send(r < 95 ? REQ_REFRESH : REQ_UNUSED, cur_x, cur_y);
            end
         end
      end
      quiet = 1'b0;

      req_valid <= 1'b0;
      while (sb.owed.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.errors == 0 && sb.owed.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
